// File: sv/yuyv_to_yuv420_converter_macros.svh
// Assertion macros used by the converter top level.
`ifndef YUYV_TO_YUV420_CONVERTER_MACROS_SVH
`define YUYV_TO_YUV420_CONVERTER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define YUV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define YUV_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: sv/yuv420_pkg.sv
// Types and constants for the YUYV to YUV 4:2:0 converter.
`default_nettype none

package yuv420_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int STORE_DEPTH = MAX_WIDTH / 2;

  localparam int COL_W  = $clog2(STORE_DEPTH);
  localparam int PAIR_W = $clog2(STORE_DEPTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ROWS_W = $clog2(MAX_HEIGHT + 1);

  localparam int CFG_W     = 13;
  localparam int REG_IDX_W = 1;
  localparam int ENTRY_W   = 14;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  luma_first_out;
    logic [7:0]  luma_second_out;
    logic [23:0] luma_index;
    logic [7:0]  chroma_blue_out;
    logic [7:0]  chroma_red_out;
    logic        chroma_valid;
    logic [21:0] chroma_index;
    logic        frame_end;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
  } cfg_t;

  // Classified beat as it leaves the front, with the line store entry.
  typedef struct packed {
    logic [7:0]         y0;
    logic [7:0]         y1;
    logic [23:0]        luma_index;
    logic [6:0]         u_half;
    logic [6:0]         v_half;
    logic               odd;
    logic [21:0]        chroma_index;
    logic               frame_end;
    logic [ENTRY_W-1:0] entry;
  } qent_t;

endpackage

`default_nettype wire

// File: sv/yuv420_ram.sv
// Generic single-clock RAM, one write and one registered read port.
`default_nettype none

module yuv420_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/yuv420_front.sv
// Front end: position counters, row classification and chroma line store.
`default_nettype none

module yuv420_front
  import yuv420_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              push,
  output      logic              full,
  input  wire in_beat_t          in_beat_i,
  input  wire logic [QCNT_W-1:0] q_cnt_i,
  output      logic              q_push_o,
  output      qent_t             q_ent_o
);

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [23:0]       lpos_q, lpos_d;
  logic [21:0]       cpos_q, cpos_d;
  logic              s1_valid_q;
  qent_t             s1_q;

  logic [CFG_W-1:0]  w_half;
  logic [PAIR_W-1:0] pairs;
  logic [ROWS_W-1:0] rows;
  logic              odd, row_end, frame_end, accept;
  logic [QCNT_W:0]   in_flight;
  logic [ENTRY_W-1:0] rdata;

  // Clamp the configured geometry.
  always_comb begin
    w_half = {1'b0, cfg_i.frame_width[CFG_W-1:1]};
    if (w_half == '0) begin
      pairs = PAIR_W'(1);
    end else if (w_half > CFG_W'(STORE_DEPTH)) begin
      pairs = PAIR_W'(STORE_DEPTH);
    end else begin
      pairs = PAIR_W'(w_half);
    end
    if (cfg_i.frame_height == '0) begin
      rows = ROWS_W'(1);
    end else if (cfg_i.frame_height > CFG_W'(MAX_HEIGHT)) begin
      rows = ROWS_W'(MAX_HEIGHT);
    end else begin
      rows = ROWS_W'(cfg_i.frame_height);
    end
  end

  assign odd       = row_q[0];
  assign row_end   = (PAIR_W'(col_q) + PAIR_W'(1)) >= pairs;
  assign frame_end = row_end && ((ROWS_W'(row_q) + ROWS_W'(1)) >= rows);

  // Credit: the stage register plus queue never exceed the queue depth.
  assign in_flight = (QCNT_W + 1)'(q_cnt_i) + (QCNT_W + 1)'(s1_valid_q);
  assign full      = in_flight >= (QCNT_W + 1)'(QDEPTH);
  assign accept    = push && !full;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    lpos_d = lpos_q;
    cpos_d = cpos_q;
    if (accept) begin
      if (frame_end) begin
        col_d  = '0;
        row_d  = '0;
        lpos_d = '0;
        cpos_d = '0;
      end else begin
        lpos_d = lpos_q + 24'd2;
        if (odd) begin
          cpos_d = cpos_q + 22'd1;
        end
        if (row_end) begin
          col_d = '0;
          row_d = row_q + ROW_W'(1);
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      lpos_q     <= '0;
      cpos_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      lpos_q     <= lpos_d;
      cpos_q     <= cpos_d;
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.y0           <= in_beat_i.luma_first;
      s1_q.y1           <= in_beat_i.luma_second;
      s1_q.luma_index   <= lpos_q;
      s1_q.u_half       <= in_beat_i.chroma_blue[7:1];
      s1_q.v_half       <= in_beat_i.chroma_red[7:1];
      s1_q.odd          <= odd;
      s1_q.chroma_index <= cpos_q;
      s1_q.frame_end    <= frame_end;
      s1_q.entry        <= '0;
    end
  end

  // Even rows write the halved pair, odd rows read it back.
  yuv420_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (accept && !odd),
    .waddr_i (col_q),
    .wdata_i ({in_beat_i.chroma_blue[7:1], in_beat_i.chroma_red[7:1]}),
    .re_i    (accept && odd),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  always_comb begin
    q_ent_o       = s1_q;
    q_ent_o.entry = rdata;
  end
  assign q_push_o = s1_valid_q;

endmodule

`default_nettype wire

// File: sv/yuv420_fifo.sv
// Short queue of classified beats between front and back.
`default_nettype none

module yuv420_fifo
  import yuv420_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire qent_t             data_i,
  input  wire logic              pop_i,
  output      qent_t             head_o,
  output      logic              nonempty_o,
  output      logic [QCNT_W-1:0] cnt_o
);

  qent_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign head_o     = mem_q[rptr_q];
  assign nonempty_o = cnt_q != '0;
  assign cnt_o      = cnt_q;

endmodule

`default_nettype wire

// File: sv/yuv420_back.sv
// Back end: chroma averaging and the output register.
`default_nettype none

module yuv420_back
  import yuv420_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire qent_t     head_i,
  input  wire logic      nonempty_i,
  output      logic      q_pop_o,
  output      logic      empty,
  input  wire logic      pop,
  output      out_beat_t out_beat_o
);

  logic      out_valid_q;
  out_beat_t out_q, out_d;

  assign q_pop_o = nonempty_i && (!out_valid_q || pop);

  always_comb begin
    out_d.luma_first_out  = head_i.y0;
    out_d.luma_second_out = head_i.y1;
    out_d.luma_index      = head_i.luma_index;
    out_d.chroma_valid    = head_i.odd;
    out_d.frame_end       = head_i.frame_end;
    if (head_i.odd) begin
      out_d.chroma_blue_out = {1'b0, head_i.entry[13:7]} + {1'b0, head_i.u_half};
      out_d.chroma_red_out  = {1'b0, head_i.entry[6:0]} + {1'b0, head_i.v_half};
      out_d.chroma_index    = head_i.chroma_index;
    end else begin
      out_d.chroma_blue_out = '0;
      out_d.chroma_red_out  = '0;
      out_d.chroma_index    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

  assign empty      = !out_valid_q;
  assign out_beat_o = out_q;

endmodule

`default_nettype wire

// File: sv/yuyv_to_yuv420_converter.sv
// Top level of the YUYV 4:2:2 to planar YUV 4:2:0 stream converter.
// Path: a pushed beat passes the read stage, the queue and the output register to reach the result side.
// Throughput: one macropixel per cycle while full is low; the line store does one access per beat.
// Read stage and queue share 4 slots, the output register holds one more: 5 beats before full.
// Reset: counters clear, width/height return to 640/480, store contents undefined.
`default_nettype none

`include "yuyv_to_yuv420_converter_macros.svh"

module yuyv_to_yuv420_converter
  import yuv420_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  // input queue side
  input  wire logic                 push,
  output      logic                 full,
  input  wire in_beat_t             in_beat_i,
  // result queue side
  output      logic                 empty,
  input  wire logic                 pop,
  output      out_beat_t            out_beat_o
);

  cfg_t              cfg_q;
  logic              q_push, q_pop, q_nonempty;
  qent_t             q_in, q_head;
  logic [QCNT_W-1:0] q_cnt;
  logic [QCNT_W:0]   credit_used;
  logic              even_ok;

  // Config registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= WIDTH_RESET;
      cfg_q.frame_height <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i;
        REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: counters, odd/even row split, line store access (one read stage).
  yuv420_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .push      (push),
    .full      (full),
    .in_beat_i (in_beat_i),
    .q_cnt_i   (q_cnt),
    .q_push_o  (q_push),
    .q_ent_o   (q_in)
  );

  // Decoupling queue; front holds credit so pushes always fit.
  yuv420_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .data_i     (q_in),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .nonempty_o (q_nonempty),
    .cnt_o      (q_cnt)
  );

  // Back: averages chroma and holds the result beat.
  yuv420_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .nonempty_i (q_nonempty),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_beat_o (out_beat_o)
  );

  // Checks
  assign credit_used = {1'b0, q_cnt} + (QCNT_W + 1)'(q_push);
  // an even-row beat on the result side carries no chroma
  assign even_ok = empty || out_beat_o.chroma_valid ||
                   ((out_beat_o.chroma_blue_out == '0) && (out_beat_o.chroma_red_out == '0) &&
                    (out_beat_o.chroma_index == '0));

  `YUV_ASSERT(a_credit, credit_used <= (QCNT_W + 1)'(QDEPTH), "queue credit overrun")
  `YUV_ASSERT_NEXT(a_push_lands, q_push, q_nonempty, "pushed beat lost from queue")
  `YUV_ASSERT(a_even_quiet, even_ok, "chroma set on even row")
  `YUV_ASSERT(a_luma_even, !empty |-> !out_beat_o.luma_index[0], "odd luma index")

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the YUYV to YUV 4:2:0 stream converter.
`timescale 1ns / 100ps

module tb_top
  import yuv420_pkg::*;
();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 150;     // long result-side hold-off to fill the block
  localparam int RANDOM_BEATS = 450;
  localparam int DRAIN_CYCLES = 8;

  // Tracks the converter state and holds the beats it should produce, oldest first.
  class yuv420_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [6:0]       u_line [STORE_DEPTH];
    logic [6:0]       v_line [STORE_DEPTH];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    logic [23:0]      luma_pos;
    logic [21:0]      chroma_pos;
    out_beat_t        expected_beats[$];
    int               accepted;
    int               checked;
    int               chroma_beats;
    int               frame_ends;
    int               errors;

    function new();
      width_reg    = WIDTH_RESET;
      height_reg   = HEIGHT_RESET;
      col_cnt      = 0;
      row_cnt      = 0;
      luma_pos     = '0;
      chroma_pos   = '0;
      accepted     = 0;
      checked      = 0;
      chroma_beats = 0;
      frame_ends   = 0;
      errors       = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH:  width_reg  = val;
        REG_FRAME_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    // Width is even: bit 0 dropped, then clamped to [2, MAX_WIDTH].
    function int unsigned pair_limit();
      int unsigned w;
      w = int'(width_reg & 13'h1FFE);
      if (w < 2) w = 2;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w / 2;
    endfunction

    function int unsigned row_limit();
      int unsigned h;
      h = int'(height_reg);
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
    endfunction

    function bit row_is_odd();
      return row_cnt[0];
    endfunction

    function void note_macropixel(in_beat_t beat);
      out_beat_t want;
      bit        odd_row;
      bit        row_end;
      bit        last_beat;
      logic [6:0] u_half;
      logic [6:0] v_half;
      odd_row   = row_cnt[0];
      row_end   = (col_cnt + 1 >= pair_limit());
      last_beat = row_end && (row_cnt + 1 >= row_limit());
      u_half    = beat.chroma_blue[7:1];
      v_half    = beat.chroma_red[7:1];

      want                 = '0;
      want.luma_first_out  = beat.luma_first;
      want.luma_second_out = beat.luma_second;
      want.luma_index      = luma_pos;
      want.frame_end       = last_beat;
      if (odd_row) begin
        // upper half from the line store plus the current half, truncated each
        want.chroma_blue_out = {1'b0, u_line[col_cnt]} + {1'b0, u_half};
        want.chroma_red_out  = {1'b0, v_line[col_cnt]} + {1'b0, v_half};
        want.chroma_valid    = 1'b1;
        want.chroma_index    = chroma_pos;
        chroma_beats++;
      end else if (col_cnt < STORE_DEPTH) begin
        u_line[col_cnt] = u_half;
        v_line[col_cnt] = v_half;
      end
      expected_beats.push_back(want);
      accepted++;

      if (last_beat) begin
        col_cnt    = 0;
        row_cnt    = 0;
        luma_pos   = '0;
        chroma_pos = '0;
        frame_ends++;
      end else begin
        luma_pos = luma_pos + 24'd2;
        if (odd_row) chroma_pos = chroma_pos + 22'd1;
        if (row_end) begin
          col_cnt = 0;
          row_cnt++;
        end else begin
          col_cnt++;
        end
      end
    endfunction

    function string beat_text(out_beat_t b);
      return $sformatf("y0=%h y1=%h li=%0d cb=%h cr=%h cv=%b ci=%0d fe=%b",
                       b.luma_first_out, b.luma_second_out, b.luma_index,
                       b.chroma_blue_out, b.chroma_red_out, b.chroma_valid,
                       b.chroma_index, b.frame_end);
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      string     diff;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %s", beat_text(got));
        return;
      end
      want = expected_beats.pop_front();
      checked++;
      diff = "";
      if (got.luma_first_out  !== want.luma_first_out)  diff = {diff, " luma_first_out"};
      if (got.luma_second_out !== want.luma_second_out) diff = {diff, " luma_second_out"};
      if (got.luma_index      !== want.luma_index)      diff = {diff, " luma_index"};
      if (got.chroma_blue_out !== want.chroma_blue_out) diff = {diff, " chroma_blue_out"};
      if (got.chroma_red_out  !== want.chroma_red_out)  diff = {diff, " chroma_red_out"};
      if (got.chroma_valid    !== want.chroma_valid)    diff = {diff, " chroma_valid"};
      if (got.chroma_index    !== want.chroma_index)    diff = {diff, " chroma_index"};
      if (got.frame_end       !== want.frame_end)       diff = {diff, " frame_end"};
      if (diff != "") begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch on beat %0d:%s", checked, diff);
          $display("  expected %s", beat_text(want));
          $display("  actual   %s", beat_text(got));
        end
      end
    endfunction

    function void check_leftover();
      if (expected_beats.size() != 0) begin
        errors++;
        $display("%0d expected beats never came out", expected_beats.size());
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 push;
  logic                 full;
  in_beat_t             in_beat_i;
  logic                 empty;
  logic                 pop;
  out_beat_t            out_beat_o;

  yuv420_scoreboard sb;
  bit               hold_req;     // main flow asks the result side for a long hold-off
  int               full_waits;   // cycles an offered beat sat against full
  int               settings;     // register writes done
  int               dir_k;        // walks the directed byte patterns

  yuyv_to_yuv420_converter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_beat_i  (in_beat_i),
    .empty      (empty),
    .pop        (pop),
    .out_beat_o (out_beat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a run that is still going here is stuck.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("TB_ERROR");
    $finish;
  end

  // Every popped beat is compared against the oldest prediction.
  // Inputs move at the falling edge, so pop and empty are stable here.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_beat(out_beat_o);
  end

  // Result side: runs of pops broken by stalls, mostly short, a few long.
  // A hold request from the main flow forces one very long stall so that
  // the queue inside the block fills and full backs up the input.
  initial begin
    int stall_left;
    int run_left;
    pop        = 1'b0;
    stall_left = 0;
    run_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
        run_left   = 0;
      end
      if (stall_left > 0) begin
        pop = 1'b0;
        stall_left--;
      end else begin
        pop = 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = $urandom_range(0, 30);
          stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                    : $urandom_range(12, 50);
        end
      end
    end
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Byte corners: zero, all ones, LSB-only, the halving boundaries and alternating bits.
  function automatic logic [7:0] corner_byte(int n);
    case (n % 8)
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      3: return 8'hFE;
      4: return 8'h80;
      5: return 8'h7F;
      6: return 8'hAA;
      default: return 8'h55;
    endcase
  endfunction

  // Offer one beat, optionally after an idle gap; returns at the falling
  // edge after the beat was taken. push drops there unless the next call
  // raises it again in the same step (blocking, so the last write wins).
  task automatic send_macropixel(input in_beat_t beat, input bit burst);
    int gap;
    gap = burst ? 0 : sender_gap();
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push      = 1'b1;
    in_beat_i = beat;
    @(posedge clk_i);
    while (full) begin
      full_waits++;
      @(posedge clk_i);
    end
    sb.note_macropixel(beat);
    @(negedge clk_i);
    push = 1'b0;
  endtask

  task automatic send_corners(input int count);
    in_beat_t beat;
    repeat (count) begin
      beat.luma_first  = corner_byte(dir_k);
      beat.chroma_blue = corner_byte(dir_k + 3);
      beat.luma_second = corner_byte(dir_k + 5);
      beat.chroma_red  = corner_byte(dir_k + 6);
      dir_k++;
      send_macropixel(beat, 1'b0);
    end
  endtask

  // Registers only change once the block has handed back everything.
  task automatic drain();
    while (sb.expected_beats.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, val);
    settings++;
  endtask

  // Config is only changed on an even row: the next odd row then reads
  // only line store entries written by the row above it.
  task automatic finish_odd_row();
    while (sb.row_is_odd()) send_macropixel(in_beat_t'($urandom), 1'b0);
  endtask

  initial begin
    logic [CFG_W-1:0] w_val;
    logic [CFG_W-1:0] h_val;
    int               r;
    int               which;
    int               n;
    int               phase;
    bit               burst;

    sb         = new();
    hold_req   = 1'b0;
    full_waits = 0;
    settings   = 0;
    dir_k      = 0;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_FRAME_WIDTH;
    cfg_data_i = '0;
    push       = 1'b0;
    in_beat_i  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: a few corner beats at the reset geometry (640x480, row 0)
    send_corners(3);
    drain();
    // shrink width mid-row: column past the new limit closes row 0 at once,
    // then an odd height so the last row only fills the store
    write_reg(REG_FRAME_WIDTH, 13'd4);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    send_corners(9);
    drain();
    // zero width and height clamp to one pair, one row: every beat ends a frame
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    send_corners(3);
    drain();
    // width 1 drops to the minimum of 2, two rows
    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    send_corners(4);
    drain();
    // all-ones registers clamp to the maximum frame
    write_reg(REG_FRAME_WIDTH, 13'h1FFF);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    send_corners(4);
    drain();
    // back to a small frame while deep in row 0
    write_reg(REG_FRAME_WIDTH, 13'd6);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    send_corners(4);

    // Random phases: new geometry, then a burst or gappy run of beats
    phase = 0;
    while (sb.accepted < dir_k + RANDOM_BEATS) begin
      phase++;
      finish_odd_row();
      drain();

      r = $urandom_range(0, 99);
      if (r < 70)      w_val = $urandom_range(2, 24);
      else if (r < 78) w_val = $urandom_range(0, 1);
      else if (r < 84) w_val = 13'd4096;
      else if (r < 88) w_val = 13'h1FFF;
      else             w_val = $urandom_range(0, 8191);
      r = $urandom_range(0, 99);
      if (r < 65)      h_val = $urandom_range(1, 6);
      else if (r < 75) h_val = 13'd0;
      else if (r < 82) h_val = 13'h1FFF;
      else if (r < 87) h_val = 13'd4096;
      else             h_val = $urandom_range(0, 8191);
      which = $urandom_range(0, 2);
      if (which != 1) write_reg(REG_FRAME_WIDTH, w_val);
      if (which != 0) write_reg(REG_FRAME_HEIGHT, h_val);

      n     = $urandom_range(20, 60);
      burst = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        // result side stops for a long while; keep offering beats back to back
        hold_req = 1'b1;
        burst    = 1'b1;
        n        = 60;
      end
      repeat (n) send_macropixel(in_beat_t'($urandom), burst);
    end

    finish_odd_row();
    drain();
    sb.check_leftover();

    $display("%0d macropixels over %0d register writes: %0d chroma beats, %0d frame ends",
             sb.accepted, settings, sb.chroma_beats, sb.frame_ends);
    $display("%0d beats checked, %0d cycles with input held by full, %0d errors",
             sb.checked, full_waits, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/yuv420_pkg.sv
sv/yuv420_ram.sv
sv/yuv420_front.sv
sv/yuv420_fifo.sv
sv/yuv420_back.sv
sv/yuyv_to_yuv420_converter.sv
sim/tb_top.sv
